// ===== hw/rtl/humidity_temp_convert_mean_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the humidity and temperature mean filter
// Concurrent assertion wrappers that compile away under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_CONVERT_MEAN_FILTER_MACROS_SVH
`define HUMIDITY_TEMP_CONVERT_MEAN_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is high.
`define HTCMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define HTCMF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTCMF_ASSERT(name, prop, msg)
`define HTCMF_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== hw/rtl/htcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// htcmf_pkg
// Shared types and constants of the humidity and temperature mean filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htcmf_pkg;

  localparam int RAW_W       = 16;
  localparam int VAL_W       = 15;
  localparam int SCALE_W     = 15;
  localparam int PROD_W      = RAW_W + SCALE_W;
  localparam int SAMPLES_W   = 4;
  localparam int IN_W        = 2 * RAW_W;
  localparam int OUT_W       = 40;
  localparam int DEFAULT_WINDOW_LEN = 10;

  localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17572;
  localparam logic [SCALE_W-1:0] HUM_SCALE   = 15'd12500;
  localparam logic [VAL_W:0]     TEMP_OFFSET = 16'd4685;
  localparam logic [VAL_W:0]     HUM_OFFSET  = 16'd600;
  localparam logic [RAW_W:0]     HUM_DIV     = 17'd65535;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_T,
    S_MUL_H,
    S_CAP_H,
    S_UPDATE,
    S_DIV_T_GO,
    S_DIV_T,
    S_DIV_H_GO,
    S_DIV_H,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sel_hum;
    logic cap_temp;
    logic cap_hum;
  } conv_ctl_t;

  typedef struct packed {
    logic rd;
    logic upd;
  } win_ctl_t;

endpackage

// ===== hw/rtl/htcmf_conv.sv =====
// ----------------------------------------------------------------------------
// htcmf_conv
// Raw code to centi-unit conversion around one shared constant multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htcmf_conv (
  input  logic                                  clk,
  input  htcmf_pkg::conv_ctl_t                  ctl,
  input  logic        [htcmf_pkg::RAW_W-1:0]    raw_temp,
  input  logic        [htcmf_pkg::RAW_W-1:0]    raw_humidity,
  output logic signed [htcmf_pkg::VAL_W-1:0]    temp_val,
  output logic signed [htcmf_pkg::VAL_W-1:0]    hum_val
);

  logic [htcmf_pkg::RAW_W-1:0]   raw_t;
  logic [htcmf_pkg::RAW_W-1:0]   raw_h;
  logic [htcmf_pkg::RAW_W-1:0]   mul_a;
  logic [htcmf_pkg::SCALE_W-1:0] mul_b;
  logic [htcmf_pkg::PROD_W-1:0]  prod;
  logic [htcmf_pkg::PROD_W-1:0]  mul_out;
  logic [htcmf_pkg::VAL_W-1:0]   q_est;
  logic [htcmf_pkg::RAW_W:0]     rem;
  logic [htcmf_pkg::VAL_W:0]     hum_q;
  logic [htcmf_pkg::VAL_W:0]     temp_calc;
  logic [htcmf_pkg::VAL_W:0]     hum_calc;

  assign mul_a   = ctl.sel_hum ? raw_h : raw_t;
  assign mul_b   = ctl.sel_hum ? htcmf_pkg::HUM_SCALE : htcmf_pkg::TEMP_SCALE;
  assign mul_out = {{htcmf_pkg::SCALE_W{1'b0}}, mul_a} * {{htcmf_pkg::RAW_W{1'b0}}, mul_b};

  // Temperature divides by 65536: the upper product bits are the floor.
  assign temp_calc = {1'b0, prod[htcmf_pkg::PROD_W-1:htcmf_pkg::RAW_W]}
                     - htcmf_pkg::TEMP_OFFSET;

  // Humidity divides by 65535. p >> 16 undershoots by at most one, and the
  // remainder p - q*65535 = p[15:0] + q stays below twice the divisor.
  assign q_est    = prod[htcmf_pkg::PROD_W-1:htcmf_pkg::RAW_W];
  assign rem      = {1'b0, prod[htcmf_pkg::RAW_W-1:0]} + {2'b00, q_est};
  assign hum_q    = {1'b0, q_est} + {{htcmf_pkg::VAL_W{1'b0}}, (rem >= htcmf_pkg::HUM_DIV)};
  assign hum_calc = hum_q - htcmf_pkg::HUM_OFFSET;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      raw_t <= raw_temp;
      raw_h <= raw_humidity;
    end
    if (ctl.mul) begin
      prod <= mul_out;
    end
    if (ctl.cap_temp) begin
      temp_val <= temp_calc[htcmf_pkg::VAL_W-1:0];
    end
    if (ctl.cap_hum) begin
      hum_val <= hum_calc[htcmf_pkg::VAL_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/htcmf_window.sv =====
// ----------------------------------------------------------------------------
// htcmf_window
// Sample ring memory with running sums and fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_temp_convert_mean_filter_macros.svh"

module htcmf_window #(
  parameter int WINDOW_LEN = htcmf_pkg::DEFAULT_WINDOW_LEN,
  parameter int CNT_W      = $clog2(WINDOW_LEN + 1),
  parameter int SUM_W      = htcmf_pkg::VAL_W + $clog2(WINDOW_LEN)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  htcmf_pkg::win_ctl_t                  ctl,
  input  logic signed [htcmf_pkg::VAL_W-1:0]   temp_val,
  input  logic signed [htcmf_pkg::VAL_W-1:0]   hum_val,
  output logic signed [SUM_W-1:0]              temp_sum,
  output logic signed [SUM_W-1:0]              hum_sum,
  output logic        [CNT_W-1:0]              fill_count
);

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int ENT_W = 2 * htcmf_pkg::VAL_W;

  logic [ENT_W-1:0] mem [WINDOW_LEN];
  logic [ENT_W-1:0] rd_data;
  logic [IDX_W-1:0] write_slot;
  logic [IDX_W-1:0] write_slot_next;
  logic             full;
  logic signed [htcmf_pkg::VAL_W-1:0] old_t;
  logic signed [htcmf_pkg::VAL_W-1:0] old_h;
  logic signed [SUM_W-1:0] temp_sum_next;
  logic signed [SUM_W-1:0] hum_sum_next;

  assign full = (fill_count == CNT_W'(WINDOW_LEN));
  assign write_slot_next = (write_slot == IDX_W'(WINDOW_LEN - 1)) ? '0 : write_slot + 1'b1;

  // The old entry only leaves the sum once the ring is full, so it was written.
  assign old_t = full ? rd_data[ENT_W-1:htcmf_pkg::VAL_W] : '0;
  assign old_h = full ? rd_data[htcmf_pkg::VAL_W-1:0] : '0;
  assign temp_sum_next = temp_sum - SUM_W'(old_t) + SUM_W'(temp_val);
  assign hum_sum_next  = hum_sum - SUM_W'(old_h) + SUM_W'(hum_val);

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      mem[write_slot] <= {temp_val, hum_val};
    end
    if (ctl.rd) begin
      rd_data <= mem[write_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      temp_sum   <= '0;
      hum_sum    <= '0;
    end else if (ctl.upd) begin
      write_slot <= write_slot_next;
      temp_sum   <= temp_sum_next;
      hum_sum    <= hum_sum_next;
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  `HTCMF_ASSERT(a_fill_bound, fill_count <= CNT_W'(WINDOW_LEN), "fill count beyond window")
  `HTCMF_ASSERT(a_slot_bound, write_slot <= IDX_W'(WINDOW_LEN - 1), "write slot beyond window")
  `HTCMF_ASSERT(a_fill_grow, ctl.upd && !full |=> fill_count == $past(fill_count) + 1'b1, "fill count did not grow")

endmodule

// ===== hw/rtl/htcmf_div.sv =====
// ----------------------------------------------------------------------------
// htcmf_div
// Bit-serial signed divider by a small unsigned count, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htcmf_div #(
  parameter int SUM_W = htcmf_pkg::VAL_W + $clog2(htcmf_pkg::DEFAULT_WINDOW_LEN),
  parameter int CNT_W = $clog2(htcmf_pkg::DEFAULT_WINDOW_LEN + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic        [CNT_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;

  assign trial = {rem, quot[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dsr});
  assign diff  = trial - {1'b0, dsr};
  assign quotient = neg ? -quot : quot;

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= (dividend < 0) ? -dividend : dividend;
      rem  <= '0;
      dsr  <= divisor;
      neg  <= (dividend < 0);
      step <= '0;
    end else if (busy) begin
      quot <= {quot[SUM_W-2:0], fits};
      rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(SUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/humidity_temp_convert_mean_filter.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_convert_mean_filter
// Converts raw temperature and humidity codes and averages them over a window.
// ----------------------------------------------------------------------------
// One input item carries a raw temperature and a raw humidity code. The block
// converts them to hundredths of a degree and of %RH, stores them in a ring of
// WINDOW_LEN samples and returns one item with the mean of the held samples
// (truncated toward zero) and the number of samples it covers.
// The bit-serial divider runs once for each mean, one quotient bit per cycle;
// the conversion multiplier is shared and used twice per item.
// s_axis_tready is high only while the sequencer is idle; one item is in work
// at a time. The output register holds a finished item while the next input
// is converted; if the receiver still stalls when the next mean is ready, the
// sequencer waits and input stays blocked.
// Reset clears the ring count, the write slot, the sums and the output valid;
// the first means cover one sample, growing to WINDOW_LEN.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_temp_convert_mean_filter_macros.svh"

module humidity_temp_convert_mean_filter #(
  parameter int WINDOW_LEN = htcmf_pkg::DEFAULT_WINDOW_LEN
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // raw_temp [15:0], raw_humidity [31:16]
  input  logic [htcmf_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mean_temp_centi [14:0], mean_humidity_centi [29:15], samples_used [33:30]
  output logic [htcmf_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = htcmf_pkg::VAL_W + $clog2(WINDOW_LEN);
  localparam int PAD_W = htcmf_pkg::OUT_W - 2 * htcmf_pkg::VAL_W - htcmf_pkg::SAMPLES_W;

  htcmf_pkg::state_t    state;
  htcmf_pkg::state_t    state_next;
  htcmf_pkg::conv_ctl_t conv_ctl;
  htcmf_pkg::win_ctl_t  win_ctl;

  logic signed [htcmf_pkg::VAL_W-1:0] temp_val;
  logic signed [htcmf_pkg::VAL_W-1:0] hum_val;
  logic signed [SUM_W-1:0]            temp_sum;
  logic signed [SUM_W-1:0]            hum_sum;
  logic        [CNT_W-1:0]            fill_count;
  logic                               div_start;
  logic                               div_sel_hum;
  logic                               div_busy;
  logic                               div_done;
  logic signed [SUM_W-1:0]            div_quot;
  logic                               cap_mean_t;
  logic                               load_out;
  logic signed [htcmf_pkg::VAL_W-1:0] mean_t;
  logic signed [htcmf_pkg::VAL_W-1:0] out_mean_t;
  logic signed [htcmf_pkg::VAL_W-1:0] out_mean_h;
  logic [htcmf_pkg::SAMPLES_W-1:0]    out_samples;
  logic                               in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  htcmf_conv u_conv (
    .clk          (clk),
    .ctl          (conv_ctl),
    .raw_temp     (s_axis_tdata[htcmf_pkg::RAW_W-1:0]),
    .raw_humidity (s_axis_tdata[htcmf_pkg::IN_W-1:htcmf_pkg::RAW_W]),
    .temp_val     (temp_val),
    .hum_val      (hum_val)
  );

  htcmf_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (win_ctl),
    .temp_val   (temp_val),
    .hum_val    (hum_val),
    .temp_sum   (temp_sum),
    .hum_sum    (hum_sum),
    .fill_count (fill_count)
  );

  htcmf_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_sel_hum ? hum_sum : temp_sum),
    .divisor  (fill_count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htcmf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      htcmf_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = htcmf_pkg::S_MUL_T;
        end
      end
      htcmf_pkg::S_MUL_T:    state_next = htcmf_pkg::S_MUL_H;
      htcmf_pkg::S_MUL_H:    state_next = htcmf_pkg::S_CAP_H;
      htcmf_pkg::S_CAP_H:    state_next = htcmf_pkg::S_UPDATE;
      htcmf_pkg::S_UPDATE:   state_next = htcmf_pkg::S_DIV_T_GO;
      htcmf_pkg::S_DIV_T_GO: state_next = htcmf_pkg::S_DIV_T;
      htcmf_pkg::S_DIV_T: begin
        if (div_done) begin
          state_next = htcmf_pkg::S_DIV_H_GO;
        end
      end
      htcmf_pkg::S_DIV_H_GO: state_next = htcmf_pkg::S_DIV_H;
      htcmf_pkg::S_DIV_H: begin
        if (div_done) begin
          state_next = htcmf_pkg::S_OUT;
        end
      end
      htcmf_pkg::S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = htcmf_pkg::S_IDLE;
        end
      end
      default: state_next = htcmf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    conv_ctl      = '0;
    win_ctl       = '0;
    div_start     = 1'b0;
    div_sel_hum   = 1'b0;
    cap_mean_t    = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      htcmf_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        conv_ctl.load = in_accept;
      end
      htcmf_pkg::S_MUL_T: begin
        conv_ctl.mul = 1'b1;
        win_ctl.rd   = 1'b1;
      end
      htcmf_pkg::S_MUL_H: begin
        conv_ctl.mul      = 1'b1;
        conv_ctl.sel_hum  = 1'b1;
        conv_ctl.cap_temp = 1'b1;
      end
      htcmf_pkg::S_CAP_H: begin
        conv_ctl.cap_hum = 1'b1;
      end
      htcmf_pkg::S_UPDATE: begin
        win_ctl.upd = 1'b1;
      end
      htcmf_pkg::S_DIV_T_GO: begin
        div_start = 1'b1;
      end
      htcmf_pkg::S_DIV_T: begin
        cap_mean_t = div_done;
      end
      htcmf_pkg::S_DIV_H_GO: begin
        div_start   = 1'b1;
        div_sel_hum = 1'b1;
      end
      htcmf_pkg::S_DIV_H: begin
        div_sel_hum = 1'b1;
      end
      htcmf_pkg::S_OUT: begin
        load_out = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // The humidity quotient stays valid in the divider until the next start.
  always_ff @(posedge clk) begin
    if (cap_mean_t) begin
      mean_t <= div_quot[htcmf_pkg::VAL_W-1:0];
    end
    if (load_out) begin
      out_mean_t  <= mean_t;
      out_mean_h  <= div_quot[htcmf_pkg::VAL_W-1:0];
      out_samples <= htcmf_pkg::SAMPLES_W'(fill_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_samples, out_mean_h, out_mean_t};

  `HTCMF_ASSERT(a_busy_blocks_input, div_busy |-> !s_axis_tready, "input taken while dividing")
  `HTCMF_ASSERT(a_out_no_overwrite, load_out |-> !m_axis_tvalid || m_axis_tready, "output overwritten")

endmodule
